// ----- rtl/core/phd_pkg.sv -----
// ----------------------------------------------------------------------------
// phd_pkg: shared definitions for the PID heater drive
// Register map, sequencer states and the fixed constants of the datapath.
// ----------------------------------------------------------------------------
package phd_pkg;

    // Port widths.
    localparam int unsigned IN_W   = 72;
    localparam int unsigned OUT_W  = 16;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Step counter and multiplier digit.
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned DIGIT_W = 4;

    // Multiplier operands are at most 24 bits, consumed 4 bits per step.
    localparam logic [CNT_W-1:0] MUL_STEPS = 6'd6;
    // Integral increment quotient is below 2^29; derivative quotient below 2^62.
    localparam logic [CNT_W-1:0] INC_STEPS = 6'd29;
    localparam logic [CNT_W-1:0] DER_STEPS = 6'd62;

    localparam logic [23:0] US_PER_SEC  = 24'd1000000;
    localparam logic [47:0] US_HALF     = 48'd500000;
    localparam logic [11:0] FF_MAX      = 12'd2560;
    localparam logic [24:0] ROUND_HALF  = 25'd32768;
    localparam logic [13:0] DRIVE_HALF  = 14'd256;

    typedef enum logic [2:0] {
        REG_SETPOINT     = 3'd0,
        REG_GAIN_P       = 3'd1,
        REG_GAIN_I       = 3'd2,
        REG_GAIN_D       = 3'd3,
        REG_WINDUP_UPPER = 3'd4,
        REG_WINDUP_LOWER = 3'd5,
        REG_OUTPUT_UPPER = 3'd6,
        REG_OUTPUT_LOWER = 3'd7
    } reg_idx_t;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_MEDT   = 12'b0000_0000_0010,
        ST_DINC   = 12'b0000_0000_0100,
        ST_CLAMPI = 12'b0000_0000_1000,
        ST_MP     = 12'b0000_0001_0000,
        ST_MI     = 12'b0000_0010_0000,
        ST_MGD    = 12'b0000_0100_0000,
        ST_MUS    = 12'b0000_1000_0000,
        ST_DDER   = 12'b0001_0000_0000,
        ST_SAT    = 12'b0010_0000_0000,
        ST_ROUND  = 12'b0100_0000_0000,
        ST_DRIVE  = 12'b1000_0000_0000
    } state_t;

endpackage

// ----- rtl/core/pid_heater_drive.sv -----
// ----------------------------------------------------------------------------
// pid_heater_drive: PID controller with anti-windup driving a heater level
// One sample in, one drive level out. Integral and previous error are kept
// between samples; gains, setpoint and limits come from an APB register file.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents (lowest bits first)
//  --------  ---------  ----------------------------------------------------
//  s_*       in         measured[23:0], feed_forward[47:24], elapsed_us[71:48]
//  m_*       out        drive_level[4:0], pid_term[12:5], zero pad [15:13]
//  APB       in/out     8 registers at byte address 4*index, 32-bit data
//
//  One sample is processed at a time; the derivative division is skipped
//  when elapsed_us is zero. The sample time is set by the shared bit-serial
//  divider (29 steps for the integral increment, 62 for the derivative) and
//  five passes of the shared 4-bit-digit multiplier.
//  Reset is synchronous and active low; it restores the register defaults
//  and clears the integral and the previous error.
//  A stalled result waits in the output register; the next sample can be
//  accepted meanwhile and only its final step waits for the register to free.
//
module pid_heater_drive (
    input  logic                            aclk,
    input  logic                            aresetn,
    // measured[23:0], feed_forward[47:24], elapsed_us[71:48]
    input  logic [phd_pkg::IN_W-1:0]        s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // drive_level[4:0], pid_term[12:5], zero pad [15:13]
    output logic [phd_pkg::OUT_W-1:0]       m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [phd_pkg::ADDR_W-1:0]      paddr,
    input  logic [phd_pkg::DATA_W-1:0]      pwdata,
    output logic [phd_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import phd_pkg::*;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [23:0] setpoint_reg;
    logic [15:0] gain_p_reg;
    logic [15:0] gain_i_reg;
    logic [15:0] gain_d_reg;
    logic [31:0] windup_upper_reg;
    logic [31:0] windup_lower_reg;
    logic [7:0]  output_upper_reg;
    logic [7:0]  output_lower_reg;

    logic     cfg_wr;
    reg_idx_t cfg_idx;

    // ------------------------------------------------------------------------
    // Sequencer, shared multiplier and divider, sample state
    // ------------------------------------------------------------------------
    state_t           state_reg,  state_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;

    // Digit-serial multiplier: the multiplier operand is shifted out four bits
    // per cycle while the multiplicand moves left by the same amount.
    logic [63:0] acc_reg,    acc_next;
    logic [63:0] mcand_reg,  mcand_next;
    logic [23:0] mplier_reg, mplier_next;

    // Bit-serial restoring divider: the dividend is shifted out of the top of
    // quo_reg while quotient bits are shifted in at the bottom.
    logic [23:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [23:0] dvs_reg, dvs_next;

    // Per-sample values.
    logic [24:0] err_reg,       err_next;
    logic [23:0] emag_reg,      emag_next;
    logic        eneg_reg,      eneg_next;
    logic [23:0] dt_reg,        dt_next;
    logic [11:0] ffc_reg,       ffc_next;
    logic [24:0] dmag_reg,      dmag_next;
    logic        dneg_reg,      dneg_next;
    logic [33:0] integ_raw_reg, integ_raw_next;
    logic [63:0] sum_reg,       sum_next;
    logic [23:0] sat_reg,       sat_next;
    logic [7:0]  pid_reg,       pid_next;

    // Controller state kept between samples.
    logic [31:0] integ_reg,    integ_next;
    logic [24:0] prev_err_reg, prev_err_next;

    // Output register.
    logic        m_tvalid_reg, m_tvalid_next;
    logic [4:0]  drive_out_reg, drive_out_next;
    logic [7:0]  pid_out_reg,   pid_out_next;

    // ------------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------------
    logic [23:0] meas_in;
    logic [23:0] ff_in;
    logic [23:0] dt_in;
    logic [24:0] err_in;
    logic [24:0] err_in_neg;
    logic [23:0] emag_in;
    logic [11:0] ffc_in;

    logic [63:0] mul_pp;
    logic [25:0] div_trial;
    logic        div_q;

    logic [47:0] inc_div;
    logic [33:0] inc_ext;
    logic [33:0] integ_ext;
    logic [33:0] integ_sum;
    logic [33:0] wu_ext;
    logic [33:0] wl_ext;
    logic [31:0] integ_clamp;

    logic [25:0] diff;
    logic [25:0] diff_neg;
    logic [24:0] dmag_in;
    logic [31:0] imag;

    logic [63:0] sum_term;
    logic        sum_term_neg;
    logic [63:0] sum_acc;
    logic [61:0] der_div;

    logic [63:0] ou_ext;
    logic [63:0] ol_ext;
    logic [23:0] sat_in;

    logic [23:0] sat_neg;
    logic [23:0] smag;
    logic [24:0] rnd;
    logic [8:0]  rq;
    logic [8:0]  rq_neg;
    logic [7:0]  pid_in;

    logic [16:0] total;
    logic [11:0] tc;
    logic [13:0] drv;
    logic        out_free;

    assign meas_in = s_tdata[23:0];
    assign ff_in   = s_tdata[47:24];
    assign dt_in   = s_tdata[71:48];

    // Error against the setpoint, kept in sign and magnitude for the multiplier.
    assign err_in     = {setpoint_reg[23], setpoint_reg} - {meas_in[23], meas_in};
    assign err_in_neg = 25'd0 - err_in;
    assign emag_in    = err_in[24] ? err_in_neg[23:0] : err_in[23:0];

    // Feed-forward limited to 0..10 units at acceptance.
    always_comb begin
        priority if (ff_in[23]) begin
            ffc_in = 12'd0;
        end else if (ff_in > {12'd0, FF_MAX}) begin
            ffc_in = FF_MAX;
        end else begin
            ffc_in = ff_in[11:0];
        end
    end

    assign mul_pp    = mcand_reg * {{(64-DIGIT_W){1'b0}}, mplier_reg[DIGIT_W-1:0]};
    assign div_trial = {1'b0, rem_reg, quo_reg[63]} - {2'b00, dvs_reg};
    assign div_q     = ~div_trial[25];

    // Integral increment: |e| * dt rounded over one million, sign restored.
    assign inc_div   = acc_reg[47:0] + US_HALF;
    assign inc_ext   = {5'd0, quo_reg[28:0]};
    assign integ_ext = {{2{integ_reg[31]}}, integ_reg};
    assign integ_sum = eneg_reg ? (integ_ext - inc_ext) : (integ_ext + inc_ext);
    assign wu_ext    = {{2{windup_upper_reg[31]}}, windup_upper_reg};
    assign wl_ext    = {{2{windup_lower_reg[31]}}, windup_lower_reg};

    // The upper limit wins when the limits cross and the value is outside both.
    always_comb begin
        priority if ($signed(integ_raw_reg) > $signed(wu_ext)) begin
            integ_clamp = windup_upper_reg;
        end else if ($signed(integ_raw_reg) < $signed(wl_ext)) begin
            integ_clamp = windup_lower_reg;
        end else begin
            integ_clamp = integ_raw_reg[31:0];
        end
    end

    assign diff     = {err_reg[24], err_reg} - {prev_err_reg[24], prev_err_reg};
    assign diff_neg = 26'd0 - diff;
    assign dmag_in  = diff[25] ? diff_neg[24:0] : diff[24:0];
    assign imag     = integ_reg[31] ? (32'd0 - integ_reg) : integ_reg;

    // One add/subtract serves the integral and derivative terms.
    assign sum_term     = (state_reg == ST_DDER) ? quo_reg : acc_reg;
    assign sum_term_neg = (state_reg == ST_DDER) ? dneg_reg : integ_reg[31];
    assign sum_acc      = sum_term_neg ? (sum_reg - sum_term) : (sum_reg + sum_term);

    assign der_div = acc_reg[61:0] + {39'd0, dt_reg[23:1]};

    assign ou_ext = {{40{output_upper_reg[7]}}, output_upper_reg, 16'd0};
    assign ol_ext = {{40{output_lower_reg[7]}}, output_lower_reg, 16'd0};

    always_comb begin
        priority if ($signed(sum_reg) > $signed(ou_ext)) begin
            sat_in = {output_upper_reg, 16'd0};
        end else if ($signed(sum_reg) < $signed(ol_ext)) begin
            sat_in = {output_lower_reg, 16'd0};
        end else begin
            sat_in = sum_reg[23:0];
        end
    end

    // Round the limited sum to whole units, halves away from zero.
    assign sat_neg = 24'd0 - sat_reg;
    assign smag    = sat_reg[23] ? sat_neg : sat_reg;
    assign rnd     = {1'b0, smag} + ROUND_HALF;
    assign rq      = rnd[24:16];
    assign rq_neg  = 9'd0 - rq;
    assign pid_in  = sat_reg[23] ? rq_neg[7:0] : rq[7:0];

    // Total in Q.8, limited to 0..10 units, then scaled by 5/512 and rounded.
    assign total = {pid_reg[7], pid_reg, 8'd0} + {5'd0, ffc_reg};

    always_comb begin
        priority if (total[16]) begin
            tc = 12'd0;
        end else if (total > {5'd0, FF_MAX}) begin
            tc = FF_MAX;
        end else begin
            tc = total[11:0];
        end
    end

    assign drv      = {tc, 2'b00} + {2'b00, tc} + DRIVE_HALF;
    assign out_free = ~m_tvalid_reg | m_tready;

    // ------------------------------------------------------------------------
    // Sequencer and datapath next state
    // ------------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        err_next       = err_reg;
        emag_next      = emag_reg;
        eneg_next      = eneg_reg;
        dt_next        = dt_reg;
        ffc_next       = ffc_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        integ_raw_next = integ_raw_reg;
        sum_next       = sum_reg;
        sat_next       = sat_reg;
        pid_next       = pid_reg;
        integ_next     = integ_reg;
        prev_err_next  = prev_err_reg;
        drive_out_next = drive_out_reg;
        pid_out_next   = pid_out_reg;
        m_tvalid_next  = m_tvalid_reg & ~m_tready;

        // While the counter runs, the active unit takes one step per cycle.
        if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (state_reg == ST_DINC || state_reg == ST_DDER) begin
                rem_next = div_q ? div_trial[23:0] : {rem_reg[22:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], div_q};
            end else begin
                acc_next    = acc_reg + mul_pp;
                mcand_next  = {mcand_reg[63-DIGIT_W:0], {DIGIT_W{1'b0}}};
                mplier_next = {{DIGIT_W{1'b0}}, mplier_reg[23:DIGIT_W]};
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        err_next    = err_in;
                        emag_next   = emag_in;
                        eneg_next   = err_in[24];
                        dt_next     = dt_in;
                        ffc_next    = ffc_in;
                        acc_next    = '0;
                        mcand_next  = {40'd0, emag_in};
                        mplier_next = dt_in;
                        cnt_next    = MUL_STEPS;
                        state_next  = ST_MEDT;
                    end
                end
                ST_MEDT: begin
                    // The quotient is below 2^29, so the top 19 dividend bits
                    // start as the remainder (always below one million).
                    rem_next   = {5'd0, inc_div[47:29]};
                    quo_next   = {inc_div[28:0], 35'd0};
                    dvs_next   = US_PER_SEC;
                    cnt_next   = INC_STEPS;
                    state_next = ST_DINC;
                end
                ST_DINC: begin
                    integ_raw_next = integ_sum;
                    state_next     = ST_CLAMPI;
                end
                ST_CLAMPI: begin
                    integ_next    = integ_clamp;
                    dmag_next     = dmag_in;
                    dneg_next     = diff[25];
                    prev_err_next = err_reg;
                    acc_next      = '0;
                    mcand_next    = {40'd0, emag_reg};
                    mplier_next   = {8'd0, gain_p_reg};
                    cnt_next      = MUL_STEPS;
                    state_next    = ST_MP;
                end
                ST_MP: begin
                    sum_next    = eneg_reg ? (64'd0 - acc_reg) : acc_reg;
                    acc_next    = '0;
                    mcand_next  = {32'd0, imag};
                    mplier_next = {8'd0, gain_i_reg};
                    cnt_next    = MUL_STEPS;
                    state_next  = ST_MI;
                end
                ST_MI: begin
                    sum_next    = sum_acc;
                    acc_next    = '0;
                    mcand_next  = {39'd0, dmag_reg};
                    mplier_next = {8'd0, gain_d_reg};
                    cnt_next    = MUL_STEPS;
                    state_next  = ST_MGD;
                end
                ST_MGD: begin
                    acc_next    = '0;
                    mcand_next  = acc_reg;
                    mplier_next = US_PER_SEC;
                    cnt_next    = MUL_STEPS;
                    state_next  = ST_MUS;
                end
                ST_MUS: begin
                    // No elapsed time means no derivative contribution.
                    if (dt_reg == '0) begin
                        state_next = ST_SAT;
                    end else begin
                        rem_next   = '0;
                        quo_next   = {der_div, 2'b00};
                        dvs_next   = dt_reg;
                        cnt_next   = DER_STEPS;
                        state_next = ST_DDER;
                    end
                end
                ST_DDER: begin
                    sum_next   = sum_acc;
                    state_next = ST_SAT;
                end
                ST_SAT: begin
                    sat_next   = sat_in;
                    state_next = ST_ROUND;
                end
                ST_ROUND: begin
                    pid_next   = pid_in;
                    state_next = ST_DRIVE;
                end
                ST_DRIVE: begin
                    if (out_free) begin
                        drive_out_next = drv[13:9];
                        pid_out_next   = pid_reg;
                        m_tvalid_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_comb begin
        unique case (cfg_idx)
            REG_SETPOINT:     prdata = {{8{setpoint_reg[23]}}, setpoint_reg};
            REG_GAIN_P:       prdata = {16'd0, gain_p_reg};
            REG_GAIN_I:       prdata = {16'd0, gain_i_reg};
            REG_GAIN_D:       prdata = {16'd0, gain_d_reg};
            REG_WINDUP_UPPER: prdata = windup_upper_reg;
            REG_WINDUP_LOWER: prdata = windup_lower_reg;
            REG_OUTPUT_UPPER: prdata = {{24{output_upper_reg[7]}}, output_upper_reg};
            REG_OUTPUT_LOWER: prdata = {{24{output_lower_reg[7]}}, output_lower_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Registers cleared by reset
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            m_tvalid_reg     <= 1'b0;
            integ_reg        <= '0;
            prev_err_reg     <= '0;
            setpoint_reg     <= '0;
            gain_p_reg       <= '0;
            gain_i_reg       <= '0;
            gain_d_reg       <= '0;
            windup_upper_reg <= '0;
            windup_lower_reg <= '0;
            output_upper_reg <= 8'sd10;
            output_lower_reg <= '0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            integ_reg    <= integ_next;
            prev_err_reg <= prev_err_next;
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_SETPOINT:     setpoint_reg     <= pwdata[23:0];
                    REG_GAIN_P:       gain_p_reg       <= pwdata[15:0];
                    REG_GAIN_I:       gain_i_reg       <= pwdata[15:0];
                    REG_GAIN_D:       gain_d_reg       <= pwdata[15:0];
                    REG_WINDUP_UPPER: windup_upper_reg <= pwdata;
                    REG_WINDUP_LOWER: windup_lower_reg <= pwdata;
                    REG_OUTPUT_UPPER: output_upper_reg <= pwdata[7:0];
                    REG_OUTPUT_LOWER: output_lower_reg <= pwdata[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Datapath registers (no reset needed)
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        acc_reg       <= acc_next;
        mcand_reg     <= mcand_next;
        mplier_reg    <= mplier_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dvs_reg       <= dvs_next;
        err_reg       <= err_next;
        emag_reg      <= emag_next;
        eneg_reg      <= eneg_next;
        dt_reg        <= dt_next;
        ffc_reg       <= ffc_next;
        dmag_reg      <= dmag_next;
        dneg_reg      <= dneg_next;
        integ_raw_reg <= integ_raw_next;
        sum_reg       <= sum_next;
        sat_reg       <= sat_next;
        pid_reg       <= pid_next;
        drive_out_reg <= drive_out_next;
        pid_out_reg   <= pid_out_next;
    end

    assign s_tready = (state_reg == ST_IDLE) && (cnt_reg == '0);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, pid_out_reg, drive_out_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
    // One sample at a time: the input is closed in the cycle after a beat is accepted.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a sample was in flight");

    // The divider remainder never reaches the divisor.
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DINC || state_reg == ST_DDER) |-> (rem_reg < dvs_reg))
        else $error("divider remainder out of range");

    // The limited PID sum never exceeds the largest output limit.
    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> ($signed(sat_reg) <= $signed(24'h7F0000)))
        else $error("limited PID sum out of range");

    // A result appears only from the final step of the sequence.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DRIVE))
        else $error("result raised outside the drive step");
`endif

endmodule
